// ===== rtl/fpvd_pkg.sv =====
// Shared constants, codes and types for the fiber point voxel density block.
// Used by the channel interfaces, the register file, the controller and the datapath.
// No dependencies.
`default_nettype none

package fpvd_pkg;

	localparam int AXIS_BITS = 6;
	localparam int AXIS_SIZE = 1 << AXIS_BITS;
	localparam int ADDR_W = 3 * AXIS_BITS;
	localparam int DEPTH = 1 << ADDR_W;

	localparam int REQ_W = 2;
	localparam int POS_W = 24;
	localparam int RD_W = 6;
	localparam int STAT_W = 2;
	localparam int VAL_W = 32;
	localparam int INV_W = 24;
	localparam int SIZE_W = 7;
	localparam int IDX_W = 24;
	localparam int PROD_W = POS_W + INV_W;
	localparam int FRAC_W = PROD_W - IDX_W;
	localparam int LIM_W = (AXIS_BITS + 1 > SIZE_W) ? AXIS_BITS + 1 : SIZE_W;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_W = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_POINT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_UPDATED = 2'd0;
	localparam logic [STAT_W-1:0] ST_SKIPPED = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

	// result value source
	localparam logic [1:0] VSEL_ZERO = 2'd0;
	localparam logic [1:0] VSEL_READ = 2'd1;
	localparam logic [1:0] VSEL_UPD  = 2'd2;

	// axis codes for the shared multiplier
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// register indexes
	localparam logic [REG_W-1:0] REG_COUNT_MODE = 3'd0;
	localparam logic [REG_W-1:0] REG_INV_X      = 3'd1;
	localparam logic [REG_W-1:0] REG_INV_Y      = 3'd2;
	localparam logic [REG_W-1:0] REG_INV_Z      = 3'd3;
	localparam logic [REG_W-1:0] REG_SIZE_X     = 3'd4;
	localparam logic [REG_W-1:0] REG_SIZE_Y     = 3'd5;
	localparam logic [REG_W-1:0] REG_SIZE_Z     = 3'd6;

	localparam logic [INV_W-1:0]  INV_RST  = 24'd65536;
	localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

	typedef struct packed {
		logic              count_mode;
		logic [INV_W-1:0]  inv_x;
		logic [INV_W-1:0]  inv_y;
		logic [INV_W-1:0]  inv_z;
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [SIZE_W-1:0] size_z;
	} cfg_t;

	typedef struct packed {
		logic              take;
		logic              clr_prev;
		logic              load_addr_rd;
		logic              mul;
		logic              rnd;
		logic [1:0]        axis;
		logic              upd_prev;
		logic              load_addr_idx;
		logic              clr_step;
		logic              st_we;
		logic [STAT_W-1:0] st_code;
		logic              out_load;
		logic              mem_wr;
		logic [1:0]        val_sel;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic in_vol;
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/fpvd_if.sv =====
// Valid/ready channel interfaces: point requests in, voxel results out.
// Depends on fpvd_pkg for field widths.
`default_nettype none

interface fpvd_point_if import fpvd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [RD_W-1:0]         read_x;
	logic [RD_W-1:0]         read_y;
	logic [RD_W-1:0]         read_z;

	modport source (output valid, req_type, pos_x, pos_y, pos_z, read_x, read_y, read_z,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, read_x, read_y, read_z,
		output ready);
endinterface

interface fpvd_result_if import fpvd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0]  voxel_value;

	modport source (output valid, status, voxel_value, input ready);
	modport sink (input valid, status, voxel_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpvd_cfg.sv =====
// APB register file: count mode, reciprocal voxel sizes and volume dimensions.
// Depends on fpvd_pkg.
`default_nettype none

module fpvd_cfg import fpvd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t             cfg_q;
	logic [REG_W-1:0] reg_sel;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_mode <= 1'b1;
			cfg_q.inv_x      <= INV_RST;
			cfg_q.inv_y      <= INV_RST;
			cfg_q.inv_z      <= INV_RST;
			cfg_q.size_x     <= SIZE_RST;
			cfg_q.size_y     <= SIZE_RST;
			cfg_q.size_z     <= SIZE_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_COUNT_MODE: cfg_q.count_mode <= pwdata[0];
				REG_INV_X:      cfg_q.inv_x      <= pwdata[INV_W-1:0];
				REG_INV_Y:      cfg_q.inv_y      <= pwdata[INV_W-1:0];
				REG_INV_Z:      cfg_q.inv_z      <= pwdata[INV_W-1:0];
				REG_SIZE_X:     cfg_q.size_x     <= pwdata[SIZE_W-1:0];
				REG_SIZE_Y:     cfg_q.size_y     <= pwdata[SIZE_W-1:0];
				REG_SIZE_Z:     cfg_q.size_z     <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_COUNT_MODE: prdata = APB_DATA_W'(cfg_q.count_mode);
			REG_INV_X:      prdata = APB_DATA_W'(cfg_q.inv_x);
			REG_INV_Y:      prdata = APB_DATA_W'(cfg_q.inv_y);
			REG_INV_Z:      prdata = APB_DATA_W'(cfg_q.inv_z);
			REG_SIZE_X:     prdata = APB_DATA_W'(cfg_q.size_x);
			REG_SIZE_Y:     prdata = APB_DATA_W'(cfg_q.size_y);
			REG_SIZE_Z:     prdata = APB_DATA_W'(cfg_q.size_z);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/fpvd_ctrl.sv =====
// Controller: clearing pass, per-item sequencing of the shared multiplier,
// volume read-modify-write and output register hand-off. Depends on fpvd_pkg.
`default_nettype none

module fpvd_ctrl import fpvd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [REQ_W-1:0] req_type,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire sts_t             sts,
	output cmd_t                  cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_RND   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_MEMRD = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic [1:0] kind_q, kind_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		kind_d   = kind_q;
		cmd      = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.mem_wr   = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take    = 1'b1;
					cmd.st_we   = 1'b1;
					cmd.st_code = ST_DONE;
					kind_d      = VSEL_ZERO;
					axis_d      = AXIS_X;
					unique case (req_type)
						REQ_POINT: state_d = S_MUL;
						REQ_START: begin
							cmd.clr_prev = 1'b1;
							state_d      = S_FIN;
						end
						REQ_READ: begin
							cmd.load_addr_rd = 1'b1;
							kind_d           = VSEL_READ;
							state_d          = S_MEMRD;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				if (axis_q == AXIS_Z) begin
					state_d = S_CMP;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_CMP: begin
				cmd.st_we = 1'b1;
				if (sts.match) begin
					cmd.st_code = ST_SKIPPED;
					state_d     = S_FIN;
				end else begin
					cmd.upd_prev = 1'b1;
					if (sts.in_vol) begin
						cmd.load_addr_idx = 1'b1;
						cmd.st_code       = ST_UPDATED;
						kind_d            = VSEL_UPD;
						state_d           = S_MEMRD;
					end else begin
						cmd.st_code = ST_OUTSIDE;
						state_d     = S_FIN;
					end
				end
			end
			S_MEMRD: state_d = S_FIN;
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.val_sel  = kind_q;
					cmd.mem_wr   = (kind_q == VSEL_UPD);
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			axis_q      <= AXIS_X;
			kind_q      <= VSEL_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			kind_q  <= kind_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fpvd_dp.sv =====
// Datapath: shared scale multiplier, round-half-even, previous-voxel memory,
// range check, density volume RAM and output payload register. Depends on fpvd_pkg.
`default_nettype none

module fpvd_dp import fpvd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic signed [POS_W-1:0] pos_x,
	input  wire logic signed [POS_W-1:0] pos_y,
	input  wire logic signed [POS_W-1:0] pos_z,
	input  wire logic [RD_W-1:0]         read_x,
	input  wire logic [RD_W-1:0]         read_y,
	input  wire logic [RD_W-1:0]         read_z,
	output logic [STAT_W-1:0]            status,
	output logic [VAL_W-1:0]             voxel_value
);

	logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic signed [POS_W-1:0]  pos_sel;
	logic        [INV_W-1:0]  inv_sel;
	logic signed [PROD_W:0]   mul_full;
	logic signed [PROD_W-1:0] prod_q;
	logic        [IDX_W-1:0]  floor_v, rounded;
	logic        [FRAC_W-1:0] frac;
	logic                     round_up;
	logic        [IDX_W-1:0]  idx_x_q, idx_y_q, idx_z_q;
	logic        [IDX_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
	logic                     prev_valid_q;
	logic        [ADDR_W-1:0] addr_q;
	logic        [VAL_W-1:0]  mem [DEPTH];
	logic        [VAL_W-1:0]  rdata_q;
	logic        [VAL_W-1:0]  new_val, wdata, out_val;
	logic        [STAT_W-1:0] status_q;
	logic        [STAT_W-1:0] out_status_q;
	logic        [VAL_W-1:0]  out_value_q;

	function automatic logic axis_inside(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] size);
		logic [LIM_W-1:0] sz;
		logic [LIM_W-1:0] lim;
		logic [LIM_W-1:0] coord;
		sz    = LIM_W'(size);
		lim   = (sz > LIM_W'(AXIS_SIZE)) ? LIM_W'(AXIS_SIZE) : sz;
		coord = LIM_W'(idx[AXIS_BITS-1:0]);
		return (idx[IDX_W-1:AXIS_BITS] == '0) && (coord < lim);
	endfunction

	// axis select for the shared multiplier
	always_comb begin
		case (cmd.axis)
			AXIS_X: begin pos_sel = pos_x_q; inv_sel = cfg.inv_x; end
			AXIS_Y: begin pos_sel = pos_y_q; inv_sel = cfg.inv_y; end
			default: begin pos_sel = pos_z_q; inv_sel = cfg.inv_z; end
		endcase
	end

	assign mul_full = pos_sel * $signed({1'b0, inv_sel});

	// floor of the Q24.24 product, then round half to even
	assign floor_v  = prod_q[PROD_W-1 -: IDX_W];
	assign frac     = prod_q[FRAC_W-1:0];
	assign round_up = frac[FRAC_W-1] && ((frac[FRAC_W-2:0] != '0) || floor_v[0]);
	assign rounded  = floor_v + IDX_W'(round_up);

	assign sts.match = prev_valid_q && (idx_x_q == prev_x_q) && (idx_y_q == prev_y_q)
		&& (idx_z_q == prev_z_q);
	assign sts.in_vol = axis_inside(idx_x_q, cfg.size_x) && axis_inside(idx_y_q, cfg.size_y)
		&& axis_inside(idx_z_q, cfg.size_z);
	assign sts.clr_last = (addr_q == '1);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pos_z_q <= pos_z;
		end
		if (cmd.mul) prod_q <= mul_full[PROD_W-1:0];
		if (cmd.rnd) begin
			case (cmd.axis)
				AXIS_X:  idx_x_q <= rounded;
				AXIS_Y:  idx_y_q <= rounded;
				default: idx_z_q <= rounded;
			endcase
		end
		if (cmd.st_we) status_q <= cmd.st_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			prev_valid_q <= 1'b0;
			addr_q       <= '0;
		end else begin
			if (cmd.clr_prev) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.upd_prev) begin
				prev_x_q     <= idx_x_q;
				prev_y_q     <= idx_y_q;
				prev_z_q     <= idx_z_q;
				prev_valid_q <= 1'b1;
			end
			if (cmd.clr_step) begin
				addr_q <= addr_q + ADDR_W'(1);
			end else if (cmd.load_addr_rd) begin
				addr_q <= {AXIS_BITS'(read_z), AXIS_BITS'(read_y), AXIS_BITS'(read_x)};
			end else if (cmd.load_addr_idx) begin
				addr_q <= {idx_z_q[AXIS_BITS-1:0], idx_y_q[AXIS_BITS-1:0],
					idx_x_q[AXIS_BITS-1:0]};
			end
		end
	end

	// count saturates at all ones; mask mode writes one
	always_comb begin
		if (cfg.count_mode) new_val = (rdata_q == '1) ? rdata_q : rdata_q + VAL_W'(1);
		else new_val = VAL_W'(1);
	end

	assign wdata = cmd.clr_step ? '0 : new_val;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) mem[addr_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[addr_q];
	end

	always_comb begin
		case (cmd.val_sel)
			VSEL_READ: out_val = rdata_q;
			VSEL_UPD:  out_val = new_val;
			default:   out_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_value_q  <= out_val;
		end
	end

	assign status      = out_status_q;
	assign voxel_value = out_value_q;

endmodule

`default_nettype wire

// ===== rtl/fiber_point_voxel_density.sv =====
// Top level of the fiber point voxel density block: APB registers, controller, datapath.
// Depends on fpvd_pkg, fpvd_if, fpvd_cfg, fpvd_ctrl and fpvd_dp.
`default_nettype none

// Maps fiber-track points to a 64x64x64 volume of 32-bit voxels, one item at a time.
// After reset the block clears the volume with point.ready low; register writes are
// taken meanwhile. For a fiber point one shared 24x25 multiplier scales the three
// axes in turn, a multiply and a round state each, then a compare state follows and,
// when a voxel is updated, a volume read and a write-back through the single-port-read,
// single-port-write volume RAM. A voxel read passes through a volume read state, a
// fiber start or unknown request goes straight to the finish state. Results sit in an
// output register; the next item is accepted while a result waits, and a finishing
// item holds in its finish state until that register is free.
module fiber_point_voxel_density import fpvd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	fpvd_point_if.sink                 point,
	fpvd_result_if.source              result
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	fpvd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.req_type  (point.req_type),
		.in_ready  (point.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpvd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.pos_x       (point.pos_x),
		.pos_y       (point.pos_y),
		.pos_z       (point.pos_z),
		.read_x      (point.read_x),
		.read_y      (point.read_y),
		.read_z      (point.read_z),
		.status      (result.status),
		.voxel_value (result.voxel_value)
	);

endmodule

`default_nettype wire

// ===== verif/fpvd_voxel_checker.sv =====
// Scoreboard for the fiber point voxel density block: tracks register writes on the APB
// port, predicts one result per accepted item and compares it with the result channel.
// Depends on fpvd_pkg and the fpvd_point_if / fpvd_result_if interfaces.

module fpvd_voxel_checker import fpvd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	fpvd_point_if                 point,
	fpvd_result_if                result,
	output int                    failures,
	output int                    results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
	} voxel_result_t;

	cfg_t              cfg;
	bit [VAL_W-1:0]    density_copy [DEPTH];
	logic [IDX_W-1:0]  last_x, last_y, last_z;
	logic              last_valid;
	voxel_result_t     awaited_voxels [$];

	// Q16.8 times Q8.16, rounded to the nearest index, ties to even
	function automatic int scale_to_voxel(input logic [POS_W-1:0] pos,
		input logic [INV_W-1:0] inv);
		longint coord, recip, biased, whole, frac;
		coord = {{(64-POS_W){pos[POS_W-1]}}, pos};
		recip = {{(64-INV_W){1'b0}}, inv};
		biased = coord * recip + (longint'(1) <<< (PROD_W - 1));
		whole = (biased >>> FRAC_W) - (longint'(1) <<< (PROD_W - 1 - FRAC_W));
		frac = biased & ((longint'(1) <<< FRAC_W) - 1);
		if (frac > (longint'(1) <<< (FRAC_W - 1)) ||
			(frac == (longint'(1) <<< (FRAC_W - 1)) && whole[0])) begin
			whole = whole + 1;
		end
		return int'(whole);
	endfunction

	function automatic bit in_volume(input int idx, input logic [SIZE_W-1:0] size);
		int lim;
		lim = (size > AXIS_SIZE) ? AXIS_SIZE : int'(size);
		return idx >= 0 && idx < lim;
	endfunction

	function automatic voxel_result_t next_voxel_result(input logic [REQ_W-1:0] req,
		input logic [POS_W-1:0] px, py, pz, input logic [RD_W-1:0] rx, ry, rz);
		voxel_result_t r;
		int ix, iy, iz;
		logic [ADDR_W-1:0] a;
		r.status = ST_DONE;
		r.value = '0;
		case (req)
			REQ_POINT: begin
				ix = scale_to_voxel(px, cfg.inv_x);
				iy = scale_to_voxel(py, cfg.inv_y);
				iz = scale_to_voxel(pz, cfg.inv_z);
				if (last_valid && ix[IDX_W-1:0] == last_x && iy[IDX_W-1:0] == last_y &&
					iz[IDX_W-1:0] == last_z) begin
					r.status = ST_SKIPPED;
				end else begin
					// remember the voxel even when it falls outside
					last_x = ix[IDX_W-1:0];
					last_y = iy[IDX_W-1:0];
					last_z = iz[IDX_W-1:0];
					last_valid = 1'b1;
					if (in_volume(ix, cfg.size_x) && in_volume(iy, cfg.size_y) &&
						in_volume(iz, cfg.size_z)) begin
						a = {iz[AXIS_BITS-1:0], iy[AXIS_BITS-1:0], ix[AXIS_BITS-1:0]};
						if (!cfg.count_mode) begin
							density_copy[a] = 1;
						end else if (density_copy[a] != '1) begin
							density_copy[a] = density_copy[a] + 1;
						end
						r.status = ST_UPDATED;
						r.value = density_copy[a];
					end else begin
						r.status = ST_OUTSIDE;
					end
				end
			end
			REQ_START: last_valid = 1'b0;
			REQ_READ: r.value = density_copy[{rz, ry, rx}];
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		voxel_result_t want;
		if (!arst_n) begin
			cfg.count_mode = 1'b1;
			cfg.inv_x = INV_RST;
			cfg.inv_y = INV_RST;
			cfg.inv_z = INV_RST;
			cfg.size_x = SIZE_RST;
			cfg.size_y = SIZE_RST;
			cfg.size_z = SIZE_RST;
			last_x = '0;
			last_y = '0;
			last_z = '0;
			last_valid = 1'b0;
			awaited_voxels.delete();
		end else begin
			// results always trail their items, so retire before predicting
			if (result.valid && result.ready) begin
				results_seen++;
				if (awaited_voxels.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: status %0d value %0d",
							result.status, result.voxel_value);
				end else begin
					want = awaited_voxels.pop_front();
					if (result.status !== want.status ||
						result.voxel_value !== want.value) begin
						failures++;
						if (failures <= 10)
							$display("result mismatch: expected status %0d value %0d, got status %0d value %0d",
								want.status, want.value, result.status, result.voxel_value);
					end
				end
			end
			if (point.valid && point.ready)
				awaited_voxels.push_back(next_voxel_result(point.req_type, point.pos_x,
					point.pos_y, point.pos_z, point.read_x, point.read_y, point.read_z));
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_COUNT_MODE: cfg.count_mode = pwdata[0];
					REG_INV_X: cfg.inv_x = pwdata[INV_W-1:0];
					REG_INV_Y: cfg.inv_y = pwdata[INV_W-1:0];
					REG_INV_Z: cfg.inv_z = pwdata[INV_W-1:0];
					REG_SIZE_X: cfg.size_x = pwdata[SIZE_W-1:0];
					REG_SIZE_Y: cfg.size_y = pwdata[SIZE_W-1:0];
					REG_SIZE_Z: cfg.size_z = pwdata[SIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== verif/fiber_point_voxel_density_tb.sv =====
// Top of the fiber point voxel density regression: clock, reset, register setup,
// directed and random fiber traffic, result back-pressure and the final verdict.
// Depends on fpvd_pkg, the channel interfaces, the block and fpvd_voxel_checker.

module fiber_point_voxel_density_tb import fpvd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
	localparam int DRAIN_CYCLES = 16;
	// the volume clear after reset alone keeps the input closed, and the limit outlasts it
	localparam int IDLE_LIMIT = 800000;
	localparam int PHASES = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int   failures;
	int   results_seen;
	int   items_sent;
	int   burst_left;
	bit   no_gaps;
	int   idle_cycles;
	int   stall_left;
	int   stall_mode;
	cfg_t cur_cfg;

	fpvd_point_if  point ();
	fpvd_result_if result ();

	fiber_point_voxel_density dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.point(point),
		.result(result)
	);

	fpvd_voxel_checker voxel_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.point(point),
		.result(result),
		.failures(failures),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: switch between back-pressure patterns whenever the stall counter runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 400);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: result.ready <= 1'b1;
			1: result.ready <= ($urandom_range(0, 3) != 0);
			2: result.ready <= ($urandom_range(0, 3) == 0);
			default: result.ready <= (stall_left % 8 == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((point.valid && point.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("fiber_point_voxel_density regression: fail");
		$finish;
	end

	task automatic reg_write(input logic [REG_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		reg_write(REG_COUNT_MODE, APB_DATA_W'(c.count_mode));
		reg_write(REG_INV_X, APB_DATA_W'(c.inv_x));
		reg_write(REG_INV_Y, APB_DATA_W'(c.inv_y));
		reg_write(REG_INV_Z, APB_DATA_W'(c.inv_z));
		reg_write(REG_SIZE_X, APB_DATA_W'(c.size_x));
		reg_write(REG_SIZE_Y, APB_DATA_W'(c.size_y));
		reg_write(REG_SIZE_Z, APB_DATA_W'(c.size_z));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
	endtask

	// hold off until every result is back, plus the block's own tail
	task automatic wait_drained();
		point.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (results_seen == items_sent);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] px, py, pz,
		input logic [RD_W-1:0] rx, ry, rz);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				point.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		point.valid <= 1'b1;
		point.req_type <= req;
		point.pos_x <= px;
		point.pos_y <= py;
		point.pos_z <= pz;
		point.read_x <= rx;
		point.read_y <= ry;
		point.read_z <= rz;
		@(posedge clk);
		while (!point.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_point(input logic [POS_W-1:0] px, py, pz);
		send_item(REQ_POINT, px, py, pz, RD_W'($urandom), RD_W'($urandom), RD_W'($urandom));
	endtask

	task automatic send_read(input logic [RD_W-1:0] rx, ry, rz);
		send_item(REQ_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), rx, ry, rz);
	endtask

	task automatic send_start();
		send_item(REQ_START, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			RD_W'($urandom), RD_W'($urandom), RD_W'($urandom));
	endtask

	// a coordinate whose scaled value lands on or next to voxel index t
	function automatic logic [POS_W-1:0] coord_near_voxel(input int t,
		input logic [INV_W-1:0] inv);
		longint num, p;
		if (inv == 0)
			return POS_W'($urandom);
		if (inv == INV_RST && $urandom_range(0, 7) == 0) begin
			p = longint'(t) * 256 + 128;
			return p[POS_W-1:0];
		end
		num = (longint'(t) <<< FRAC_W) + longint'($urandom_range(0, 24'hFFFFFF)) -
			longint'(24'h800000);
		p = num / longint'(inv);
		if (p > longint'(24'h7FFFFF))
			p = longint'(24'h7FFFFF);
		if (p < -longint'(24'h800000))
			p = -longint'(24'h800000);
		return p[POS_W-1:0];
	endfunction

	function automatic int axis_limit(input logic [SIZE_W-1:0] size);
		return (size > AXIS_SIZE) ? AXIS_SIZE : int'(size);
	endfunction

	function automatic int start_index(input int lim);
		if (lim == 0)
			return int'($urandom_range(0, 4)) - 2;
		case ($urandom_range(0, 9))
			0: return -1;
			1: return lim;
			default: return int'($urandom_range(0, lim - 1));
		endcase
	endfunction

	// one fiber: a short walk through neighboring voxels, with read-backs mixed in
	task automatic run_fiber(input bit with_start);
		int n, tx, ty, tz;
		n = $urandom_range(2, 24);
		tx = start_index(axis_limit(cur_cfg.size_x));
		ty = start_index(axis_limit(cur_cfg.size_y));
		tz = start_index(axis_limit(cur_cfg.size_z));
		if (with_start)
			send_start();
		repeat (n) begin
			send_point(coord_near_voxel(tx, cur_cfg.inv_x), coord_near_voxel(ty, cur_cfg.inv_y),
				coord_near_voxel(tz, cur_cfg.inv_z));
			if ($urandom_range(0, 5) == 0)
				send_read(tx[RD_W-1:0], ty[RD_W-1:0], tz[RD_W-1:0]);
			if ($urandom_range(0, 4) != 0) begin
				tx += int'($urandom_range(0, 2)) - 1;
				ty += int'($urandom_range(0, 2)) - 1;
				tz += int'($urandom_range(0, 2)) - 1;
			end
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_point(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
			1: send_item(REQ_UNKNOWN, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
				RD_W'($urandom), RD_W'($urandom), RD_W'($urandom));
			2: send_read(RD_W'($urandom), RD_W'($urandom), RD_W'($urandom));
			default: send_start();
		endcase
	endtask

	function automatic logic [INV_W-1:0] rand_inv();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return INV_W'($urandom_range(24'h2000, 24'h60000));
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 7))
			0: return SIZE_W'($urandom_range(65, 127));
			default: return SIZE_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic cfg_t phase_config(input int p);
		cfg_t c;
		c.count_mode = 1'b1;
		c.inv_x = INV_RST;
		c.inv_y = INV_RST;
		c.inv_z = INV_RST;
		c.size_x = SIZE_RST;
		c.size_y = SIZE_RST;
		c.size_z = SIZE_RST;
		case (p)
			0: ;
			1: begin
				c.inv_x = 24'h020000;
				c.inv_y = 24'h008000;
				c.size_y = 7'd32;
				c.size_z = 7'd16;
			end
			2: begin
				c.count_mode = 1'b0;
				c.inv_x = '0;
				c.inv_y = '1;
				c.size_x = 7'd127;
				c.size_z = 7'd1;
			end
			3: begin
				// nothing can land inside with a zero size
				c.inv_x = rand_inv();
				c.inv_y = rand_inv();
				c.size_z = 7'd0;
			end
			default: begin
				c.count_mode = 1'($urandom_range(0, 1));
				c.inv_x = rand_inv();
				c.inv_y = rand_inv();
				c.inv_z = rand_inv();
				c.size_x = rand_size();
				c.size_y = rand_size();
				c.size_z = rand_size();
			end
		endcase
		return c;
	endfunction

	initial begin
		cfg_t c;
		int quota, first;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		point.valid = 1'b0;
		point.req_type = REQ_POINT;
		point.pos_x = '0;
		point.pos_y = '0;
		point.pos_z = '0;
		point.read_x = '0;
		point.read_y = '0;
		point.read_z = '0;
		result.ready = 1'b0;
		items_sent = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		idle_cycles = 0;
		stall_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_config(phase_config(0));

		// directed: cleared volume, rounding ties, skips, outside, extremes
		send_read(6'd0, 6'd0, 6'd0);
		send_read(6'd63, 6'd63, 6'd63);
		send_start();
		send_point(24'h000000, 24'h000000, 24'h000000);
		send_point(24'h000040, 24'h00007F, 24'hFFFF81);
		send_point(24'h000080, 24'h000080, 24'h000080);
		send_point(24'h000180, 24'h000180, 24'h000180);
		send_point(24'hFFFF80, 24'hFFFF80, 24'hFFFF80);
		send_start();
		send_point(24'h000000, 24'h000000, 24'h000000);
		send_point(24'hFFFE80, 24'h000000, 24'h000000);
		send_point(24'hFFFE80, 24'h000000, 24'h000000);
		send_point(24'd16128, 24'd16128, 24'd16128);
		send_point(24'd16384, 24'h000000, 24'h000000);
		send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'h800000, 24'h800000);
		send_item(REQ_UNKNOWN, '1, '1, '1, '1, '1, '1);
		send_read(6'd2, 6'd2, 6'd2);
		send_read(6'd0, 6'd0, 6'd0);
		send_start();

		// directed: mask mode, zero reciprocal, largest reciprocal, oversized axis
		wait_drained();
		apply_config(phase_config(2));
		send_point(24'h7FFFFF, 24'h000000, 24'h000000);
		send_read(6'd0, 6'd0, 6'd0);
		send_point(24'h123456, 24'h000001, 24'h000000);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			c = phase_config(p);
			apply_config(c);
			no_gaps = ($urandom_range(0, 3) == 0);
			quota = (p == 3) ? 100 : 248;
			first = items_sent;
			while (items_sent - first < quota) begin
				case ($urandom_range(0, 19))
					14: run_fiber(1'b0);
					15, 16: send_noise();
					17: send_read(RD_W'($urandom), RD_W'($urandom), RD_W'($urandom));
					18: if ($urandom_range(0, 1) == 0) wait_drained();
					default: run_fiber(1'b1);
				endcase
			end
		end

		wait_drained();
		if (failures == 0 && results_seen == items_sent)
			$display("fiber_point_voxel_density regression: pass");
		else
			$display("fiber_point_voxel_density regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fpvd_pkg.sv
rtl/fpvd_if.sv
rtl/fpvd_cfg.sv
rtl/fpvd_ctrl.sv
rtl/fpvd_dp.sv
rtl/fiber_point_voxel_density.sv
verif/fpvd_voxel_checker.sv
verif/fiber_point_voxel_density_tb.sv
